// ===== rtl/lsfr_pkg.sv =====
// shared types and constants for the link session frame responder
// used by every module under rtl, no dependencies
`default_nettype none

package lsfr_pkg;

    localparam logic [15:0] DEFAULT_PAYLOAD = 16'd256;
    localparam logic [15:0] INITIAL_CREDIT  = 16'd1024;
    localparam logic [15:0] RATE_MASK_RESET = 16'h03ff;
    localparam logic [11:0] HELLO_LEN       = 12'd6;
    localparam logic [15:0] BASE_RATE_BIT   = 16'd1;

    localparam logic [2:0] CLASS_HELLO = 3'd0;
    localparam logic [2:0] CLASS_RESET = 3'd1;
    localparam logic [2:0] CLASS_DATA  = 3'd2;
    localparam logic [2:0] CLASS_PROBE = 3'd3;
    localparam logic [2:0] CLASS_PING  = 3'd4;

    typedef enum logic [2:0] {
        OP_HELLO,
        OP_HELLO_BAD,
        OP_RESET,
        OP_DATA,
        OP_PROBE,
        OP_PING,
        OP_OTHER
    } op_t;

    typedef enum logic [2:0] {
        RT_READY,
        RT_ACK,
        RT_ERROR,
        RT_RESET_ACK,
        RT_PROBE_ACK,
        RT_PONG
    } rtype_t;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_BAD_LEN,
        ERR_SEQ,
        ERR_RX_OVERFLOW,
        ERR_UNEXPECTED
    } ecode_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  raw;
        logic [15:0] seq;
        logic [15:0] ack;
        logic [11:0] len;
        logic [15:0] hello_payload;
        logic [15:0] hello_credit;
        logic [15:0] hello_mask;
        logic        rx_fit;
        logic [15:0] rx_left;
        logic [15:0] dup_credit;
    } cmd_t;

    typedef struct packed {
        rtype_t      rtype;
        logic [15:0] seq;
        logic [15:0] ack;
        logic [15:0] ready_payload;
        logic [15:0] ready_credit;
        logic [15:0] ready_rate_mask;
        logic [15:0] ack_credit;
        ecode_t      ecode;
        logic [7:0]  edetail;
        logic        deliver;
        logic        link_reset;
        logic        last;
    } reply_t;

endpackage

`default_nettype wire

// ===== rtl/lsfr_front.sv =====
// front end: holds the rate mask register and classifies each frame item
// into a command for the back end; depends on lsfr_pkg
`default_nettype none

module lsfr_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_wr_en,
    input  wire logic [15:0]         cfg_wr_data,
    input  wire logic [2:0]          frame_class,
    input  wire logic [7:0]          raw_type,
    input  wire logic [15:0]         frame_seq,
    input  wire logic [15:0]         frame_ack,
    input  wire logic [11:0]         payload_len,
    input  wire logic [15:0]         req_payload,
    input  wire logic [15:0]         req_credit,
    input  wire logic [15:0]         req_rate_mask,
    input  wire logic [15:0]         rx_free,
    input  wire logic                rx_present,
    output lsfr_pkg::cmd_t           cmd
);

    logic [15:0] supported_rate_mask_reg;
    logic [15:0] len_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            supported_rate_mask_reg <= lsfr_pkg::RATE_MASK_RESET;
        end
        else if (cfg_wr_en)
        begin
            supported_rate_mask_reg <= cfg_wr_data;
        end
    end

    assign len_ext = {4'd0, payload_len};

    always_comb
    begin
        cmd.raw           = raw_type;
        cmd.seq           = frame_seq;
        cmd.ack           = frame_ack;
        cmd.len           = payload_len;
        cmd.hello_payload = (req_payload < lsfr_pkg::DEFAULT_PAYLOAD) ?
                            req_payload : lsfr_pkg::DEFAULT_PAYLOAD;
        cmd.hello_credit  = (req_credit < lsfr_pkg::INITIAL_CREDIT) ?
                            req_credit : lsfr_pkg::INITIAL_CREDIT;
        cmd.hello_mask    = (req_rate_mask & supported_rate_mask_reg) |
                            lsfr_pkg::BASE_RATE_BIT;
        cmd.rx_fit        = rx_present && (rx_free >= len_ext);
        cmd.rx_left       = rx_free - len_ext;
        cmd.dup_credit    = rx_present ? rx_free : 16'd0;
        case (frame_class)
            lsfr_pkg::CLASS_HELLO:
            begin
                if (payload_len != lsfr_pkg::HELLO_LEN || req_payload == 16'd0 ||
                    req_credit == 16'd0)
                begin
                    cmd.op = lsfr_pkg::OP_HELLO_BAD;
                end
                else
                begin
                    cmd.op = lsfr_pkg::OP_HELLO;
                end
            end
            lsfr_pkg::CLASS_RESET: cmd.op = lsfr_pkg::OP_RESET;
            lsfr_pkg::CLASS_DATA:  cmd.op = lsfr_pkg::OP_DATA;
            lsfr_pkg::CLASS_PROBE: cmd.op = lsfr_pkg::OP_PROBE;
            lsfr_pkg::CLASS_PING:  cmd.op = lsfr_pkg::OP_PING;
            default:               cmd.op = lsfr_pkg::OP_OTHER;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/lsfr_queue.sv =====
// short command queue between front and back end
// depends on lsfr_pkg for the command type
`default_nettype none

module lsfr_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr_en,
    input  wire lsfr_pkg::cmd_t  wr_data,
    input  wire logic            rd_en,
    output lsfr_pkg::cmd_t       rd_data,
    output logic                 full,
    output logic                 empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    lsfr_pkg::cmd_t   entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lsfr_back.sv =====
// back end: session state, reply generation and the output register
// depends on lsfr_pkg
`default_nettype none

module lsfr_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire lsfr_pkg::cmd_t  cmd,
    input  wire logic            cmd_valid,
    output logic                 cmd_take,
    input  wire logic            out_pop,
    output logic                 out_valid,
    output lsfr_pkg::reply_t     out_reply
);

    logic [15:0]      expected_seq_reg;
    logic [15:0]      expected_seq_next;
    logic [15:0]      negotiated_size_reg;
    logic [15:0]      negotiated_size_next;
    logic [15:0]      credit_limit_reg;
    logic [15:0]      credit_limit_next;
    logic [15:0]      rate_mask_now_reg;
    logic [15:0]      rate_mask_now_next;
    logic             phase_reg;
    logic             phase_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    lsfr_pkg::reply_t out_reply_reg;
    lsfr_pkg::reply_t reply_next;
    logic             load;
    logic [15:0]      seq_plus;
    logic [15:0]      len_ext;

    assign out_valid = out_valid_reg;
    assign out_reply = out_reply_reg;
    assign load      = cmd_valid && (!out_valid_reg || out_pop);
    assign seq_plus  = expected_seq_reg + 16'd1;
    assign len_ext   = {4'd0, cmd.len};

    always_comb
    begin
        expected_seq_next    = expected_seq_reg;
        negotiated_size_next = negotiated_size_reg;
        credit_limit_next    = credit_limit_reg;
        rate_mask_now_next   = rate_mask_now_reg;
        phase_next           = phase_reg;
        cmd_take             = 1'b0;
        reply_next           = '0;
        reply_next.rtype     = lsfr_pkg::RT_READY;
        reply_next.ecode     = lsfr_pkg::ERR_NONE;
        reply_next.last      = 1'b1;
        if (load)
        begin
            cmd_take = 1'b1;
            case (cmd.op)
                lsfr_pkg::OP_HELLO:
                begin
                    expected_seq_next          = 16'd0;
                    negotiated_size_next       = cmd.hello_payload;
                    credit_limit_next          = cmd.hello_credit;
                    rate_mask_now_next         = cmd.hello_mask;
                    reply_next.ready_payload   = cmd.hello_payload;
                    reply_next.ready_credit    = cmd.hello_credit;
                    reply_next.ready_rate_mask = cmd.hello_mask;
                    reply_next.link_reset      = 1'b1;
                end
                lsfr_pkg::OP_HELLO_BAD:
                begin
                    reply_next.rtype = lsfr_pkg::RT_ERROR;
                    reply_next.ecode = lsfr_pkg::ERR_BAD_LEN;
                end
                lsfr_pkg::OP_RESET:
                begin
                    if (!phase_reg)
                    begin
                        cmd_take              = 1'b0;
                        phase_next            = 1'b1;
                        expected_seq_next     = 16'd0;
                        reply_next.rtype      = lsfr_pkg::RT_RESET_ACK;
                        reply_next.seq        = cmd.seq;
                        reply_next.ack        = cmd.ack;
                        reply_next.link_reset = 1'b1;
                        reply_next.last       = 1'b0;
                    end
                    else
                    begin
                        phase_next                 = 1'b0;
                        reply_next.ready_payload   = negotiated_size_reg;
                        reply_next.ready_credit    = credit_limit_reg;
                        reply_next.ready_rate_mask = rate_mask_now_reg;
                    end
                end
                lsfr_pkg::OP_DATA:
                begin
                    if (cmd.seq == expected_seq_reg - 16'd1)
                    begin
                        reply_next.rtype      = lsfr_pkg::RT_ACK;
                        reply_next.ack        = expected_seq_reg;
                        reply_next.ack_credit = cmd.dup_credit;
                    end
                    else if (cmd.seq != expected_seq_reg)
                    begin
                        reply_next.rtype   = lsfr_pkg::RT_ERROR;
                        reply_next.ecode   = lsfr_pkg::ERR_SEQ;
                        reply_next.edetail = cmd.seq[7:0];
                    end
                    else if (cmd.len == 12'd0 || len_ext > negotiated_size_reg)
                    begin
                        reply_next.rtype   = lsfr_pkg::RT_ERROR;
                        reply_next.ecode   = lsfr_pkg::ERR_BAD_LEN;
                        reply_next.edetail = cmd.len[7:0];
                    end
                    else if (!cmd.rx_fit)
                    begin
                        reply_next.rtype   = lsfr_pkg::RT_ERROR;
                        reply_next.ecode   = lsfr_pkg::ERR_RX_OVERFLOW;
                        reply_next.edetail = cmd.len[7:0];
                    end
                    else
                    begin
                        expected_seq_next     = seq_plus;
                        reply_next.rtype      = lsfr_pkg::RT_ACK;
                        reply_next.ack        = seq_plus;
                        reply_next.ack_credit = cmd.rx_left;
                        reply_next.deliver    = 1'b1;
                    end
                end
                lsfr_pkg::OP_PROBE:
                begin
                    reply_next.rtype = lsfr_pkg::RT_PROBE_ACK;
                    reply_next.seq   = cmd.seq;
                    reply_next.ack   = cmd.ack;
                end
                lsfr_pkg::OP_PING:
                begin
                    reply_next.rtype = lsfr_pkg::RT_PONG;
                    reply_next.seq   = cmd.seq;
                    reply_next.ack   = cmd.ack;
                end
                default:
                begin
                    reply_next.rtype   = lsfr_pkg::RT_ERROR;
                    reply_next.ecode   = lsfr_pkg::ERR_UNEXPECTED;
                    reply_next.edetail = cmd.raw;
                end
            endcase
        end
    end

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_pop)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_seq_reg    <= 16'd0;
            negotiated_size_reg <= lsfr_pkg::DEFAULT_PAYLOAD;
            credit_limit_reg    <= lsfr_pkg::INITIAL_CREDIT;
            rate_mask_now_reg   <= lsfr_pkg::RATE_MASK_RESET;
            phase_reg           <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            expected_seq_reg    <= expected_seq_next;
            negotiated_size_reg <= negotiated_size_next;
            credit_limit_reg    <= credit_limit_next;
            rate_mask_now_reg   <= rate_mask_now_next;
            phase_reg           <= phase_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reply_reg <= reply_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/link_session_frame_responder_core.sv =====
// top level of the link session frame responder: front end, command queue,
// back end; depends on lsfr_pkg, lsfr_front, lsfr_queue, lsfr_back
//
//  channel   handshake            payload
//  frames    push / full          frame_class .. rx_present
//  replies   empty / pop          reply_type .. last
//  config    cfg_wr_en            cfg_wr_data (supported rate mask)
//
// one frame item per cycle while full is low; a reset frame gives two
// replies, which leave through the single output register in turn
// each reply passes through the command queue and the output register
// full rises when the command queue holds QUEUE_DEPTH items; the queue
// lets frames keep arriving while the reply side is stalled by pop
// rst_n empties the queue and returns the session state and the rate mask
// register to their reset values
`default_nettype none

module link_session_frame_responder_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        push,
    output logic             full,
    input  wire logic [2:0]  frame_class,
    input  wire logic [7:0]  raw_type,
    input  wire logic [15:0] frame_seq,
    input  wire logic [15:0] frame_ack,
    input  wire logic [11:0] payload_len,
    input  wire logic [15:0] req_payload,
    input  wire logic [15:0] req_credit,
    input  wire logic [15:0] req_rate_mask,
    input  wire logic [15:0] rx_free,
    input  wire logic        rx_present,
    output logic             empty,
    input  wire logic        pop,
    output logic [2:0]       reply_type,
    output logic [15:0]      reply_seq,
    output logic [15:0]      reply_ack,
    output logic [15:0]      ready_payload,
    output logic [15:0]      ready_credit,
    output logic [15:0]      ready_rate_mask,
    output logic [15:0]      ack_credit,
    output logic [2:0]       error_code,
    output logic [7:0]       error_detail,
    output logic             deliver_payload,
    output logic             link_reset,
    output logic             last
);

    lsfr_pkg::cmd_t   front_cmd;
    lsfr_pkg::cmd_t   head_cmd;
    lsfr_pkg::reply_t reply;
    logic             queue_empty;
    logic             cmd_take;
    logic             out_valid;

    lsfr_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .frame_class   (frame_class),
        .raw_type      (raw_type),
        .frame_seq     (frame_seq),
        .frame_ack     (frame_ack),
        .payload_len   (payload_len),
        .req_payload   (req_payload),
        .req_credit    (req_credit),
        .req_rate_mask (req_rate_mask),
        .rx_free       (rx_free),
        .rx_present    (rx_present),
        .cmd           (front_cmd)
    );

    lsfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (front_cmd),
        .rd_en   (cmd_take),
        .rd_data (head_cmd),
        .full    (full),
        .empty   (queue_empty)
    );

    lsfr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (head_cmd),
        .cmd_valid (!queue_empty),
        .cmd_take  (cmd_take),
        .out_pop   (pop && out_valid),
        .out_valid (out_valid),
        .out_reply (reply)
    );

    assign empty           = !out_valid;
    assign reply_type      = reply.rtype;
    assign reply_seq       = reply.seq;
    assign reply_ack       = reply.ack;
    assign ready_payload   = reply.ready_payload;
    assign ready_credit    = reply.ready_credit;
    assign ready_rate_mask = reply.ready_rate_mask;
    assign ack_credit      = reply.ack_credit;
    assign error_code      = reply.ecode;
    assign error_detail    = reply.edetail;
    assign deliver_payload = reply.deliver;
    assign link_reset      = reply.link_reset;
    assign last            = reply.last;

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// self-checking testbench for link_session_frame_responder_core
// predicts each reply from its own session model and compares every field
// depends on rtl/lsfr_pkg.sv and rtl/link_session_frame_responder_core.sv
`timescale 1ns / 100ps

module testbench;

    localparam logic [2:0] CLASS_OTHER   = 3'd5;
    localparam logic [2:0] CLASS_SPARE_A = 3'd6;
    localparam logic [2:0] CLASS_SPARE_B = 3'd7;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_FRAMES = 275;

    typedef struct packed {
        logic [2:0]  cls;
        logic [7:0]  raw;
        logic [15:0] seq;
        logic [15:0] ack;
        logic [11:0] len;
        logic [15:0] rpay;
        logic [15:0] rcred;
        logic [15:0] rmask;
        logic [15:0] rfree;
        logic        present;
    } frame_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        push;
    logic        full;
    logic [2:0]  frame_class;
    logic [7:0]  raw_type;
    logic [15:0] frame_seq;
    logic [15:0] frame_ack;
    logic [11:0] payload_len;
    logic [15:0] req_payload;
    logic [15:0] req_credit;
    logic [15:0] req_rate_mask;
    logic [15:0] rx_free;
    logic        rx_present;
    logic        empty;
    logic        pop;
    logic [2:0]  reply_type;
    logic [15:0] reply_seq;
    logic [15:0] reply_ack;
    logic [15:0] ready_payload;
    logic [15:0] ready_credit;
    logic [15:0] ready_rate_mask;
    logic [15:0] ack_credit;
    logic [2:0]  error_code;
    logic [7:0]  error_detail;
    logic        deliver_payload;
    logic        link_reset;
    logic        last;

    lsfr_pkg::reply_t pending_replies[$];
    logic [15:0] rate_mask_reg;
    logic [15:0] exp_seq;
    logic [15:0] negotiated_size;
    logic [15:0] credit_limit;
    logic [15:0] rate_mask_now;
    int          frames_sent;
    int          replies_seen;
    int          mismatches;
    int          mask_writes;
    int          cycles;
    int          send_idle_pct;
    int          pop_stall_pct;

    link_session_frame_responder_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .push            (push),
        .full            (full),
        .frame_class     (frame_class),
        .raw_type        (raw_type),
        .frame_seq       (frame_seq),
        .frame_ack       (frame_ack),
        .payload_len     (payload_len),
        .req_payload     (req_payload),
        .req_credit      (req_credit),
        .req_rate_mask   (req_rate_mask),
        .rx_free         (rx_free),
        .rx_present      (rx_present),
        .empty           (empty),
        .pop             (pop),
        .reply_type      (reply_type),
        .reply_seq       (reply_seq),
        .reply_ack       (reply_ack),
        .ready_payload   (ready_payload),
        .ready_credit    (ready_credit),
        .ready_rate_mask (ready_rate_mask),
        .ack_credit      (ack_credit),
        .error_code      (error_code),
        .error_detail    (error_detail),
        .deliver_payload (deliver_payload),
        .link_reset      (link_reset),
        .last            (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic lsfr_pkg::reply_t ready_reply();
        lsfr_pkg::reply_t r;
        r = '0;
        r.rtype = lsfr_pkg::RT_READY;
        r.ready_payload = negotiated_size;
        r.ready_credit = credit_limit;
        r.ready_rate_mask = rate_mask_now;
        return r;
    endfunction

    function automatic lsfr_pkg::reply_t error_reply(lsfr_pkg::ecode_t code,
                                                     logic [7:0] detail);
        lsfr_pkg::reply_t r;
        r = '0;
        r.rtype = lsfr_pkg::RT_ERROR;
        r.ecode = code;
        r.edetail = detail;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic void predict_replies(frame_t f);
        lsfr_pkg::reply_t r;
        logic [15:0]      prev_seq;
        r = '0;
        prev_seq = exp_seq - 16'd1;
        case (f.cls)
            lsfr_pkg::CLASS_HELLO:
            begin
                if (f.len != lsfr_pkg::HELLO_LEN || f.rpay == 16'd0 || f.rcred == 16'd0)
                    r = error_reply(lsfr_pkg::ERR_BAD_LEN, 8'd0);
                else
                begin
                    exp_seq = 16'd0;
                    negotiated_size = (f.rpay < lsfr_pkg::DEFAULT_PAYLOAD) ?
                                      f.rpay : lsfr_pkg::DEFAULT_PAYLOAD;
                    credit_limit = (f.rcred < lsfr_pkg::INITIAL_CREDIT) ?
                                   f.rcred : lsfr_pkg::INITIAL_CREDIT;
                    rate_mask_now = (f.rmask & rate_mask_reg) | lsfr_pkg::BASE_RATE_BIT;
                    r = ready_reply();
                    r.link_reset = 1'b1;
                    r.last = 1'b1;
                end
            end
            lsfr_pkg::CLASS_RESET:
            begin
                exp_seq = 16'd0;
                r.rtype = lsfr_pkg::RT_RESET_ACK;
                r.seq = f.seq;
                r.ack = f.ack;
                r.link_reset = 1'b1;
                pending_replies.push_back(r);
                r = ready_reply();
                r.last = 1'b1;
            end
            lsfr_pkg::CLASS_DATA:
            begin
                if (f.seq == prev_seq)
                begin
                    r.rtype = lsfr_pkg::RT_ACK;
                    r.ack = exp_seq;
                    r.ack_credit = f.present ? f.rfree : 16'd0;
                    r.last = 1'b1;
                end
                else if (f.seq != exp_seq)
                    r = error_reply(lsfr_pkg::ERR_SEQ, f.seq[7:0]);
                else if (f.len == 12'd0 || {4'd0, f.len} > negotiated_size)
                    r = error_reply(lsfr_pkg::ERR_BAD_LEN, f.len[7:0]);
                else if (!f.present || f.rfree < {4'd0, f.len})
                    r = error_reply(lsfr_pkg::ERR_RX_OVERFLOW, f.len[7:0]);
                else
                begin
                    exp_seq = exp_seq + 16'd1;
                    r.rtype = lsfr_pkg::RT_ACK;
                    r.ack = exp_seq;
                    r.ack_credit = f.rfree - {4'd0, f.len};
                    r.deliver = 1'b1;
                    r.last = 1'b1;
                end
            end
            lsfr_pkg::CLASS_PROBE, lsfr_pkg::CLASS_PING:
            begin
                if (f.cls == lsfr_pkg::CLASS_PROBE)
                    r.rtype = lsfr_pkg::RT_PROBE_ACK;
                else
                    r.rtype = lsfr_pkg::RT_PONG;
                r.seq = f.seq;
                r.ack = f.ack;
                r.last = 1'b1;
            end
            default:
                r = error_reply(lsfr_pkg::ERR_UNEXPECTED, f.raw);
        endcase
        pending_replies.push_back(r);
    endfunction

    function automatic frame_t blank_frame(logic [2:0] cls);
        frame_t f;
        f = '0;
        f.cls = cls;
        return f;
    endfunction

    function automatic frame_t random_frame();
        frame_t f;
        int     pick;
        f.cls = 3'($urandom_range(0, 7));
        f.raw = 8'($urandom);
        f.seq = 16'($urandom);
        f.ack = 16'($urandom);
        f.len = 12'($urandom);
        f.rpay = 16'($urandom);
        f.rcred = 16'($urandom);
        f.rmask = 16'($urandom);
        f.rfree = 16'($urandom);
        f.present = 1'($urandom_range(0, 1));
        pick = int'($urandom_range(0, 99));
        if (pick < 78)
            f.cls = lsfr_pkg::CLASS_DATA;
        if (pick < 55)
        begin
            f.seq = exp_seq;
            f.len = 12'($urandom_range(1, negotiated_size));
            f.present = 1'b1;
            case ($urandom_range(0, 3))
                0, 1: f.rfree = 16'(f.len + $urandom_range(0, 16'hffff - f.len));
                2: f.rfree = 16'(f.len + $urandom_range(0, 3));
                default: ;
            endcase
        end
        else if (pick < 63)
            f.seq = exp_seq - 16'd1;
        else if (pick < 73)
        begin
            if (pick < 68)
                f.seq = 16'($urandom);
            else
            begin
                f.seq = exp_seq;
                if ($urandom_range(0, 1))
                    f.len = 12'd0;
                else
                    f.len = 12'($urandom_range(negotiated_size + 1, 4095));
            end
        end
        else if (pick < 78)
        begin
            f.seq = exp_seq;
            f.len = 12'($urandom_range(1, negotiated_size));
            if (f.present)
                f.rfree = 16'($urandom_range(0, f.len - 1));
        end
        else if (pick < 86)
        begin
            f.cls = lsfr_pkg::CLASS_HELLO;
            if ($urandom_range(0, 4) != 0)
                f.len = lsfr_pkg::HELLO_LEN;
            if ($urandom_range(0, 1))
                f.rpay = 16'($urandom_range(1, 300));
            if ($urandom_range(0, 1))
                f.rcred = 16'($urandom_range(0, 2000));
        end
        else if (pick < 90)
            f.cls = lsfr_pkg::CLASS_RESET;
        else if (pick < 94)
            f.cls = lsfr_pkg::CLASS_PROBE;
        else if (pick < 97)
            f.cls = lsfr_pkg::CLASS_PING;
        else
            f.cls = 3'($urandom_range(CLASS_OTHER, CLASS_SPARE_B));
        return f;
    endfunction

    task automatic send_frame(frame_t f);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
        @(negedge clk);
        push <= 1'b1;
        frame_class <= f.cls;
        raw_type <= f.raw;
        frame_seq <= f.seq;
        frame_ack <= f.ack;
        payload_len <= f.len;
        req_payload <= f.rpay;
        req_credit <= f.rcred;
        req_rate_mask <= f.rmask;
        rx_free <= f.rfree;
        rx_present <= f.present;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_replies(f);
        frames_sent++;
    endtask

    task automatic wait_until_idle();
        @(negedge clk);
        push <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_rate_mask(logic [15:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        rate_mask_reg = value;
        mask_writes++;
    endtask

    task automatic check_field(string label, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s expected %h actual %h", $time, label, want, got);
        end
    endtask

    task automatic test_hello_negotiation();
        frame_t f;
        f = blank_frame(lsfr_pkg::CLASS_HELLO);
        f.len = 12'd5;
        f.rpay = 16'd100;
        f.rcred = 16'd100;
        send_frame(f);
        f.len = lsfr_pkg::HELLO_LEN;
        f.rpay = 16'd0;
        send_frame(f);
        f.rpay = 16'd100;
        f.rcred = 16'd0;
        send_frame(f);
        wait_until_idle();
        write_rate_mask(16'h0000);
        f.rpay = 16'd1;
        f.rcred = 16'd1;
        f.rmask = 16'hffff;
        send_frame(f);
        wait_until_idle();
        write_rate_mask(16'hffff);
        f.rpay = 16'hffff;
        f.rcred = 16'hffff;
        send_frame(f);
    endtask

    task automatic test_link_reset();
        frame_t f;
        f = blank_frame(lsfr_pkg::CLASS_RESET);
        f.seq = 16'hffff;
        f.ack = 16'hffff;
        send_frame(f);
        f.seq = 16'h0000;
        f.ack = 16'h8001;
        send_frame(f);
    endtask

    task automatic test_data_checks();
        frame_t f;
        f = blank_frame(lsfr_pkg::CLASS_DATA);
        // duplicate of the frame before sequence zero
        f.seq = exp_seq - 16'd1;
        f.rfree = 16'd1234;
        f.len = 12'd20;
        send_frame(f);
        f.present = 1'b1;
        f.rfree = 16'hffff;
        send_frame(f);
        f.seq = 16'h12ab;
        send_frame(f);
        f.seq = exp_seq;
        f.len = 12'd0;
        send_frame(f);
        f.len = 12'hfff;
        send_frame(f);
        f.len = negotiated_size[11:0] + 12'd1;
        send_frame(f);
        f.len = 12'd10;
        f.present = 1'b0;
        f.rfree = 16'd100;
        send_frame(f);
        f.present = 1'b1;
        f.rfree = 16'd9;
        send_frame(f);
        f.len = negotiated_size[11:0];
        f.rfree = negotiated_size;
        send_frame(f);
        f.seq = exp_seq;
        f.len = 12'd1;
        f.rfree = 16'hffff;
        send_frame(f);
    endtask

    task automatic test_echo_frames();
        frame_t f;
        f = blank_frame(lsfr_pkg::CLASS_PROBE);
        f.seq = 16'hffff;
        f.ack = 16'hffff;
        send_frame(f);
        f = blank_frame(lsfr_pkg::CLASS_PING);
        send_frame(f);
        f.seq = 16'h5a5a;
        f.ack = 16'ha5a5;
        send_frame(f);
    endtask

    task automatic test_unknown_class();
        frame_t f;
        f = blank_frame(CLASS_OTHER);
        send_frame(f);
        f.cls = CLASS_SPARE_A;
        f.raw = 8'hff;
        send_frame(f);
        f.cls = CLASS_SPARE_B;
        f.raw = 8'h3c;
        send_frame(f);
    endtask

    task automatic test_random_traffic(int idle_pct, int stall_pct, logic [15:0] mask);
        wait_until_idle();
        write_rate_mask(mask);
        send_idle_pct = idle_pct;
        pop_stall_pct = stall_pct;
        repeat (RANDOM_FRAMES) send_frame(random_frame());
    endtask

    initial
    begin : reply_checker
        lsfr_pkg::reply_t want;
        pop = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && !empty && pop)
            begin
                replies_seen++;
                if (pending_replies.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: reply type %0d arrived with no frame waiting", $time,
                             reply_type);
                end
                else
                begin
                    want = pending_replies.pop_front();
                    check_field("reply_type", 16'(want.rtype), 16'(reply_type));
                    check_field("reply_seq", want.seq, reply_seq);
                    check_field("reply_ack", want.ack, reply_ack);
                    check_field("ready_payload", want.ready_payload, ready_payload);
                    check_field("ready_credit", want.ready_credit, ready_credit);
                    check_field("ready_rate_mask", want.ready_rate_mask, ready_rate_mask);
                    check_field("ack_credit", want.ack_credit, ack_credit);
                    check_field("error_code", 16'(want.ecode), 16'(error_code));
                    check_field("error_detail", 16'(want.edetail), 16'(error_detail));
                    check_field("deliver_payload", 16'(want.deliver), 16'(deliver_payload));
                    check_field("link_reset", 16'(want.link_reset), 16'(link_reset));
                    check_field("last", 16'(want.last), 16'(last));
                end
            end
            @(negedge clk);
            pop <= rst_n && ($urandom_range(0, 99) >= pop_stall_pct);
        end
    end

    initial
    begin : watchdog
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("link_session_frame_responder_core: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 16'd0;
        push = 1'b0;
        frame_class = 3'd0;
        raw_type = 8'd0;
        frame_seq = 16'd0;
        frame_ack = 16'd0;
        payload_len = 12'd0;
        req_payload = 16'd0;
        req_credit = 16'd0;
        req_rate_mask = 16'd0;
        rx_free = 16'd0;
        rx_present = 1'b0;
        rate_mask_reg = lsfr_pkg::RATE_MASK_RESET;
        exp_seq = 16'd0;
        negotiated_size = lsfr_pkg::DEFAULT_PAYLOAD;
        credit_limit = lsfr_pkg::INITIAL_CREDIT;
        rate_mask_now = lsfr_pkg::RATE_MASK_RESET;
        frames_sent = 0;
        replies_seen = 0;
        mismatches = 0;
        mask_writes = 0;
        send_idle_pct = 0;
        pop_stall_pct = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_hello_negotiation();
        test_link_reset();
        test_data_checks();
        test_echo_frames();
        test_unknown_class();
        test_random_traffic(0, 0, 16'h0000);
        test_random_traffic(64, 0, 16'hffff);
        test_random_traffic(0, 64, 16'($urandom));
        test_random_traffic(11, 11, lsfr_pkg::RATE_MASK_RESET);

        wait_until_idle();
        repeat (8) @(posedge clk);
        $display("sent %0d frames (hello, reset, data, echo, unknown) over four idle mixes",
                 frames_sent);
        $display("checked %0d replies, %0d rate mask writes, %0d field errors",
                 replies_seen, mask_writes, mismatches);
        if (mismatches == 0)
            $display("link_session_frame_responder_core: match");
        else
            $display("link_session_frame_responder_core: mismatch");
        $finish;
    end

endmodule

// ===== link_session_frame_responder_core.f =====
rtl/lsfr_pkg.sv
rtl/lsfr_front.sv
rtl/lsfr_queue.sv
rtl/lsfr_back.sv
rtl/link_session_frame_responder_core.sv
tb/sv/testbench.sv
